### hw/rtl/ffpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffpa_pkg;

  localparam int WORD_BYTES   = 8;
  localparam int WORD_SHIFT   = 3;
  localparam int HEADER_BYTES = 8;
  localparam int HDR_W        = 16;

  localparam logic [13:0] POOL_BYTES_RESET = 14'd8192;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [13:0] byte_count;
    logic [12:0] offset;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [12:0] offset_res;
    logic [13:0] largest_bytes;
  } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/ffpa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ffpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/first_fit_pool_allocator_unit.sv
// Init writes the first header; free reads its header and clears the used bit, unless the offset is bad.
// Query and allocate walk the list; a hit adds split and mark steps; an empty list is not walked.
// One header is visited per cycle, set by the single read port of the header RAM.
// One command is in flight; the next is taken the cycle after its response is loaded,
// and a held response blocks only the next one.
// Synchronous reset clears control, sets pool_bytes to 8192 and empties the list, not the RAM.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_pool_allocator_unit #(
  parameter int POOL_WORDS = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [13:0]    cfg_data,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire ffpa_pkg::cmd_t cmd,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output ffpa_pkg::rsp_t      rsp
);

  localparam int IDX_W     = $clog2(POOL_WORDS);
  localparam int WS        = ffpa_pkg::WORD_SHIFT;
  localparam int POS_W     = (IDX_W + WS > 17) ? IDX_W + WS : 17;
  localparam int CAP_BYTES = POOL_WORDS * ffpa_pkg::WORD_BYTES;
  localparam int HB        = ffpa_pkg::HEADER_BYTES;
  localparam int HW        = ffpa_pkg::HDR_W;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INIT    = 9'b000000010,
    S_WALK    = 9'b000000100,
    S_EVAL    = 9'b000001000,
    S_SPLIT   = 9'b000010000,
    S_MARK    = 9'b000100000,
    S_FREE_RD = 9'b001000000,
    S_FREE_WR = 9'b010000000,
    S_RESP    = 9'b100000000
  } state_t;

  state_t state;

  logic [13:0]      pool_bytes;
  logic [13:0]      end_pos;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] run;
  logic [HW-1:0]    run_size;
  logic [HW-1:0]    best;
  logic             open;
  logic             want;
  logic [14:0]      need;
  ffpa_pkg::rsp_t   result;

  logic             ram_we;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [HW-1:0]    ram_wdata;
  logic [HW-1:0]    ram_rdata_w;
  logic [HW-1:0]    h;

  logic             h_free;
  logic [HW-1:0]    merged;
  logic [HW-1:0]    run_size_now;
  logic [HW-1:0]    best_now;
  logic             hit;
  logic [POS_W-1:0] pos_next;
  logic             more;
  logic [16:0]      remain;
  logic             split;
  logic [POS_W-1:0] split_pos;
  logic             split_ok;
  logic [13:0]      pool_cap;
  logic [13:0]      pool_al;
  logic             pool_short;
  logic [12:0]      free_hp;
  logic             free_ok;
  logic [14:0]      need_in;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);

  // Walk datapath: a free header just read either opens a free run or grows the open one; a used one closes it.
  assign h            = ram_rdata_w;
  assign h_free       = ~h[0];
  assign merged       = run_size + h + HW'(HB);
  assign run_size_now = open ? merged : h;
  assign hit          = want && h_free && ({2'b00, need} <= {1'b0, run_size_now});
  assign best_now     = (h_free && (run_size_now > best)) ? run_size_now : best;
  assign pos_next     = pos + POS_W'({h[HW-1:1], 1'b0}) + POS_W'(HB);
  assign more         = pos_next < POS_W'(end_pos);

  assign remain    = {1'b0, run_size} - {2'b00, need};
  assign split     = remain >= 17'(HB + ffpa_pkg::WORD_BYTES);
  assign split_pos = run + POS_W'(need) + POS_W'(HB);
  assign split_ok  = (32'(split_pos) >> WS) < 32'(POOL_WORDS);

  assign pool_cap   = ({18'd0, pool_bytes} > 32'(CAP_BYTES)) ? 14'(CAP_BYTES) : pool_bytes;
  assign pool_al    = pool_cap & ~14'(ffpa_pkg::WORD_BYTES - 1);
  assign pool_short = pool_al < 14'(2 * HB);

  assign free_hp = cmd.offset - 13'(HB);
  assign free_ok = (cmd.offset >= 13'(HB)) && (free_hp[WS-1:0] == '0)
                   && ({1'b0, free_hp} < end_pos);
  assign need_in = (15'(cmd.byte_count) + 15'(ffpa_pkg::WORD_BYTES - 1))
                   & ~15'(ffpa_pkg::WORD_BYTES - 1);

  // In the evaluate state the next header address is issued straight from the adder.
  assign rd_idx = (state == S_EVAL) ? pos_next[IDX_W+WS-1:WS] : pos[IDX_W+WS-1:WS];

  always_comb begin
    ram_we    = 1'b0;
    wr_idx    = run[IDX_W+WS-1:WS];
    ram_wdata = merged;
    unique case (state)
      S_INIT: begin
        ram_we    = ~pool_short;
        wr_idx    = '0;
        ram_wdata = HW'(pool_al) - HW'(2 * HB);
      end
      S_EVAL: begin
        ram_we    = h_free && open;
        wr_idx    = run[IDX_W+WS-1:WS];
        ram_wdata = merged;
      end
      S_SPLIT: begin
        ram_we    = split && split_ok;
        wr_idx    = split_pos[IDX_W+WS-1:WS];
        ram_wdata = HW'(remain - 17'(HB));
      end
      S_MARK: begin
        ram_we    = 1'b1;
        wr_idx    = run[IDX_W+WS-1:WS];
        ram_wdata = split ? (HW'(need) | HW'(1)) : (run_size | HW'(1));
      end
      S_FREE_WR: begin
        ram_we    = 1'b1;
        wr_idx    = pos[IDX_W+WS-1:WS];
        ram_wdata = h & ~HW'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ffpa_ram #(
    .WIDTH(HW),
    .DEPTH(POOL_WORDS)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx),
    .wdata(ram_wdata),
    .raddr(rd_idx),
    .rdata(ram_rdata_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      pool_bytes <= ffpa_pkg::POOL_BYTES_RESET;
      end_pos    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pool_bytes <= cfg_data;
      end
      if (rsp_valid && !rsp_stall && (state != S_RESP)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            result.status        <= (cmd.op == ffpa_pkg::OP_ALLOC) && (end_pos == '0);
            result.offset_res    <= '0;
            result.largest_bytes <= '0;
            unique case (cmd.op)
              ffpa_pkg::OP_INIT: begin
                state <= S_INIT;
              end
              ffpa_pkg::OP_ALLOC, ffpa_pkg::OP_QUERY: begin
                want  <= (cmd.op == ffpa_pkg::OP_ALLOC);
                need  <= need_in;
                pos   <= '0;
                open  <= 1'b0;
                best  <= '0;
                state <= (end_pos == '0) ? S_RESP : S_WALK;
              end
              ffpa_pkg::OP_FREE: begin
                pos   <= POS_W'(free_hp);
                state <= free_ok ? S_FREE_RD : S_RESP;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_INIT: begin
          end_pos <= pool_short ? '0 : pool_al - 14'(HB);
          state   <= S_RESP;
        end
        S_WALK: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (h_free) begin
            if (!open) begin
              open <= 1'b1;
              run  <= pos;
            end
            run_size <= run_size_now;
            best     <= best_now;
          end else begin
            open <= 1'b0;
          end
          if (hit) begin
            state <= S_SPLIT;
          end else if (more) begin
            pos <= pos_next;
          end else begin
            result.status        <= want;
            result.largest_bytes <= want ? '0 : best_now[13:0];
            state                <= S_RESP;
          end
        end
        S_SPLIT: begin
          state <= S_MARK;
        end
        S_MARK: begin
          result.offset_res <= 13'(run + POS_W'(HB));
          state             <= S_RESP;
        end
        S_FREE_RD: begin
          state <= S_FREE_WR;
        end
        S_FREE_WR: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= result;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A merge write goes to the run head, which always lies behind the header being fetched.
  a_merge_no_collision: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && ram_we) |-> (wr_idx != rd_idx))
    else $error("merge write collides with header fetch");

  a_split_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT) |-> ({2'b00, need} <= {1'b0, run_size}))
    else $error("chosen run is smaller than the request");

  a_walk_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (pos < POS_W'(end_pos)))
    else $error("walk evaluates a header past the end of the list");

endmodule

`default_nettype wire
